// ===== rtl/core/sfd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sfd_pkg - shared types and constants of the serial frame deframer
// Parse phases, configuration register indexes, reset values of the sync
// bytes and the result beat record.
// ----------------------------------------------------------------------------
package sfd_pkg;

    localparam int BYTE_W = 8;
    localparam int CFG_INDEX_W = 1;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_FIRST_HEADER  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SECOND_HEADER = 1'b1;

    localparam logic [BYTE_W-1:0] FIRST_HEADER_RESET  = 8'hAA;
    localparam logic [BYTE_W-1:0] SECOND_HEADER_RESET = 8'h55;

    // Result kinds
    localparam logic KIND_PAYLOAD   = 1'b0;
    localparam logic KIND_FRAME_END = 1'b1;

    typedef enum logic [2:0] {
        PH_HDR1 = 3'd0,
        PH_HDR2 = 3'd1,
        PH_TYPE = 3'd2,
        PH_LEN  = 3'd3,
        PH_DATA = 3'd4,
        PH_SUM  = 3'd5
    } phase_t;

    typedef struct packed {
        logic              result_kind;
        logic [BYTE_W-1:0] data_byte;
        logic [BYTE_W-1:0] byte_index;
        logic [BYTE_W-1:0] frame_type;
        logic [BYTE_W-1:0] frame_length;
        logic              checksum_ok;
    } result_t;

endpackage
`default_nettype wire

// ===== rtl/core/sfd_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sfd_if - stream channels of the serial frame deframer
// sfd_byte_if carries received bytes, sfd_result_if carries result beats.
// ----------------------------------------------------------------------------
interface sfd_byte_if;
    logic                       valid;
    logic                       ready;
    logic [sfd_pkg::BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sfd_result_if;
    logic                       valid;
    logic                       ready;
    logic                       result_kind;
    logic [sfd_pkg::BYTE_W-1:0] data_byte;
    logic [sfd_pkg::BYTE_W-1:0] byte_index;
    logic [sfd_pkg::BYTE_W-1:0] frame_type;
    logic [sfd_pkg::BYTE_W-1:0] frame_length;
    logic                       checksum_ok;

    modport source (
        output valid, output result_kind, output data_byte, output byte_index,
        output frame_type, output frame_length, output checksum_ok,
        input ready
    );
    modport sink (
        input valid, input result_kind, input data_byte, input byte_index,
        input frame_type, input frame_length, input checksum_ok,
        output ready
    );
endinterface
`default_nettype wire

// ===== rtl/core/serial_frame_deframer_xor.sv =====
`default_nettype none
// Output timing: a payload or checksum beat's result is registered at the edge
//   that accepts it if the result register is empty or draining, else it is parked in the skid entry.
// Throughput: one received byte per cycle while the skid entry is free; the
//   parse state updates in the same cycle a byte is accepted, and a two-entry
//   output stage keeps input running while one result waits.
// Reset: rst_n (async, active low) returns to the first-header hunt, clears
//   the checksum and frame state, empties the output stage, loads 0xAA/0x55.
// ----------------------------------------------------------------------------
// serial_frame_deframer_xor - header/type/length/payload/XOR frame deframer
// Hunts two sync bytes, captures type and length, emits each payload byte
// with its index and one end beat carrying the checksum verdict.
// ----------------------------------------------------------------------------
module serial_frame_deframer_xor (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_wr_en,
    input  wire logic [sfd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [sfd_pkg::BYTE_W-1:0]      cfg_data,
    sfd_byte_if.sink                             rx,
    sfd_result_if.source                         res
);

    // ------------------------------------------------------------------
    // Configuration registers: sync byte values
    // ------------------------------------------------------------------
    logic [sfd_pkg::BYTE_W-1:0] first_hdr_reg;
    logic [sfd_pkg::BYTE_W-1:0] second_hdr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_hdr_reg  <= sfd_pkg::FIRST_HEADER_RESET;
            second_hdr_reg <= sfd_pkg::SECOND_HEADER_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                sfd_pkg::CFG_FIRST_HEADER:  first_hdr_reg  <= cfg_data;
                sfd_pkg::CFG_SECOND_HEADER: second_hdr_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Parse state
    // ------------------------------------------------------------------
    sfd_pkg::phase_t             phase_reg, phase_next;
    logic [sfd_pkg::BYTE_W-1:0]  xor_reg, xor_next;
    logic [sfd_pkg::BYTE_W-1:0]  type_reg, type_next;
    logic [sfd_pkg::BYTE_W-1:0]  length_reg, length_next;
    logic [sfd_pkg::BYTE_W-1:0]  count_reg, count_next;

    logic                        accept;
    logic [sfd_pkg::BYTE_W-1:0]  b;
    logic [sfd_pkg::BYTE_W:0]    count_inc;   // one bit wider: count + 1 may reach 256
    logic                        last_payload;

    // Output stage: result register plus a skid entry
    logic                        out_valid_reg;
    sfd_pkg::result_t            out_reg;
    logic                        skid_valid_reg;
    sfd_pkg::result_t            skid_reg;

    logic                        emit;
    sfd_pkg::result_t            result;
    logic                        out_pop;

    // Stall input only when the skid entry is taken.
    assign rx.ready = !skid_valid_reg;
    assign accept   = rx.valid && rx.ready;
    assign b        = rx.rx_byte;

    assign count_inc    = {1'b0, count_reg} + {{sfd_pkg::BYTE_W{1'b0}}, 1'b1};
    assign last_payload = count_inc >= {1'b0, length_reg};

    // Next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (accept)
        begin
            unique case (phase_reg)
                sfd_pkg::PH_HDR2:
                    phase_next = (b == second_hdr_reg) ? sfd_pkg::PH_TYPE : sfd_pkg::PH_HDR1;
                sfd_pkg::PH_TYPE:
                    phase_next = sfd_pkg::PH_LEN;
                sfd_pkg::PH_LEN:
                    // A zero length goes straight to the checksum byte.
                    phase_next = (b == '0) ? sfd_pkg::PH_SUM : sfd_pkg::PH_DATA;
                sfd_pkg::PH_DATA:
                    phase_next = last_payload ? sfd_pkg::PH_SUM : sfd_pkg::PH_DATA;
                sfd_pkg::PH_SUM:
                    phase_next = sfd_pkg::PH_HDR1;
                default:
                    // First-header hunt; also recovers from unused codes.
                    phase_next = (b == first_hdr_reg) ? sfd_pkg::PH_HDR2 : sfd_pkg::PH_HDR1;
            endcase
        end
    end

    // Datapath and result
    always_comb
    begin
        xor_next    = xor_reg;
        type_next   = type_reg;
        length_next = length_reg;
        count_next  = count_reg;
        emit        = 1'b0;

        result.result_kind  = sfd_pkg::KIND_PAYLOAD;
        result.data_byte    = b;
        result.byte_index   = count_reg;
        result.frame_type   = type_reg;
        result.frame_length = length_reg;
        result.checksum_ok  = 1'b0;

        if (accept)
        begin
            unique case (phase_reg)
                sfd_pkg::PH_HDR2:
                begin
                    if (b == second_hdr_reg)
                        xor_next = xor_reg ^ b;
                end
                sfd_pkg::PH_TYPE:
                begin
                    type_next = b;
                    xor_next  = xor_reg ^ b;
                end
                sfd_pkg::PH_LEN:
                begin
                    length_next = b;
                    count_next  = '0;
                    xor_next    = xor_reg ^ b;
                end
                sfd_pkg::PH_DATA:
                begin
                    xor_next   = xor_reg ^ b;
                    count_next = count_inc[sfd_pkg::BYTE_W-1:0];
                    emit       = 1'b1;
                end
                sfd_pkg::PH_SUM:
                begin
                    // End beat: received checksum against the running XOR.
                    emit               = 1'b1;
                    result.result_kind = sfd_pkg::KIND_FRAME_END;
                    result.byte_index  = '0;
                    result.checksum_ok = (xor_reg == b);
                end
                default:
                begin
                    // Restart the checksum on a first header byte.
                    if (b == first_hdr_reg)
                        xor_next = b;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= sfd_pkg::PH_HDR1;
            xor_reg    <= '0;
            type_reg   <= '0;
            length_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            xor_reg    <= xor_next;
            type_reg   <= type_next;
            length_reg <= length_next;
            count_reg  <= count_next;
        end
    end

    // ------------------------------------------------------------------
    // Output stage: advance skid into the result register when it drains,
    // otherwise park a new result in the skid entry.
    // ------------------------------------------------------------------
    assign out_pop = out_valid_reg && res.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || out_pop)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= emit;
            end
        end
        else if (emit)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || out_pop)
            out_reg <= skid_valid_reg ? skid_reg : result;
        else if (emit)
            skid_reg <= result;
    end

    assign res.valid        = out_valid_reg;
    assign res.result_kind  = out_reg.result_kind;
    assign res.data_byte    = out_reg.data_byte;
    assign res.byte_index   = out_reg.byte_index;
    assign res.frame_type   = out_reg.frame_type;
    assign res.frame_length = out_reg.frame_length;
    assign res.checksum_ok  = out_reg.checksum_ok;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held while result register empty");

    a_no_result_in_header: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (phase_reg == sfd_pkg::PH_HDR1 || phase_reg == sfd_pkg::PH_HDR2 ||
                    phase_reg == sfd_pkg::PH_TYPE || phase_reg == sfd_pkg::PH_LEN))
        |-> !emit)
        else $error("result emitted for a header, type or length byte");

    a_count_below_length: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == sfd_pkg::PH_DATA) |-> (count_reg < length_reg))
        else $error("payload count reached length while still in payload");

    a_end_returns_to_hunt: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && phase_reg == sfd_pkg::PH_SUM) |=> (phase_reg == sfd_pkg::PH_HDR1))
        else $error("checksum byte did not return to the header hunt");

endmodule
`default_nettype wire

// ===== tb/tb_serial_frame_deframer_xor.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tb_serial_frame_deframer_xor - self-checking bench of the XOR frame deframer
// Streams received bytes into the block and predicts every payload beat and
// frame-end beat on the side. Results are checked field by field, in order.
// The byte and result channels both idle and stall at random. Sync byte
// registers are changed between phases. Traffic runs from directed frames
// to a long random mix of good, corrupted, broken and noise sequences.
// ----------------------------------------------------------------------------
module tb_serial_frame_deframer_xor;

    import sfd_pkg::*;

    typedef logic [BYTE_W-1:0] byte_q_t[$];

    localparam int RANDOM_BYTES  = 1200;
    // Longest correct quiet stretch is a long gap or stall, well under this.
    localparam int IDLE_LIMIT    = 2000;
    // Margin after the last expected beat for the output stage to settle.
    localparam int SETTLE_CYCLES = 4;
    localparam int MAX_REPORTS   = 200;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_wr_en;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [BYTE_W-1:0]      cfg_data;

    sfd_byte_if   rx ();
    sfd_result_if res ();

    serial_frame_deframer_xor dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .rx        (rx),
        .res       (res)
    );

    // ------------------------------------------------------------------
    // Predicted deframer: sync bytes, parse phase and frame bookkeeping
    // ------------------------------------------------------------------
    logic [BYTE_W-1:0] sync1       = FIRST_HEADER_RESET;
    logic [BYTE_W-1:0] sync2       = SECOND_HEADER_RESET;
    phase_t            hunt_phase  = PH_HDR1;
    logic [BYTE_W-1:0] frame_xor   = '0;
    logic [BYTE_W-1:0] held_type   = '0;
    logic [BYTE_W-1:0] held_len    = '0;
    logic [BYTE_W-1:0] payload_idx = '0;

    result_t expected_beats[$];
    int      error_count = 0;
    int      frame_bytes = 0;
    int      idle_cycles = 0;
    int      stall_left  = 0;
    bit      steady      = 1'b0;   // both sides run back to back while set

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Advance the predicted parser by one received byte. Return 1 and fill
    // beat when the byte gives a result.
    function automatic bit deframe_byte(input logic [BYTE_W-1:0] b, output result_t beat);
        bit got;
        got  = 1'b0;
        beat = '0;
        case (hunt_phase)
            PH_HDR2:
            begin
                // A mismatch drops back to the hunt; this byte is not
                // retried as a first sync byte.
                if (b == sync2)
                begin
                    frame_xor  = frame_xor ^ b;
                    hunt_phase = PH_TYPE;
                end
                else
                    hunt_phase = PH_HDR1;
            end
            PH_TYPE:
            begin
                held_type  = b;
                frame_xor  = frame_xor ^ b;
                hunt_phase = PH_LEN;
            end
            PH_LEN:
            begin
                held_len    = b;
                payload_idx = '0;
                frame_xor   = frame_xor ^ b;
                // A zero length goes straight to the checksum byte.
                hunt_phase  = (b == '0) ? PH_SUM : PH_DATA;
            end
            PH_DATA:
            begin
                beat.result_kind  = KIND_PAYLOAD;
                beat.data_byte    = b;
                beat.byte_index   = payload_idx;
                beat.frame_type   = held_type;
                beat.frame_length = held_len;
                beat.checksum_ok  = 1'b0;
                frame_xor = frame_xor ^ b;
                if ({1'b0, payload_idx} + 9'd1 >= {1'b0, held_len})
                    hunt_phase = PH_SUM;
                payload_idx = payload_idx + 8'd1;
                got = 1'b1;
            end
            PH_SUM:
            begin
                // A failed checksum still gives the end beat, flagged bad.
                beat.result_kind  = KIND_FRAME_END;
                beat.data_byte    = b;
                beat.byte_index   = '0;
                beat.frame_type   = held_type;
                beat.frame_length = held_len;
                beat.checksum_ok  = (frame_xor == b);
                hunt_phase = PH_HDR1;
                got = 1'b1;
            end
            default:
            begin
                if (b == sync1)
                begin
                    frame_xor  = b;
                    hunt_phase = PH_HDR2;
                end
                else
                    hunt_phase = PH_HDR1;
            end
        endcase
        return got;
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 24);
    endfunction

    task automatic check_field(input string name, input logic [BYTE_W-1:0] want,
                               input logic [BYTE_W-1:0] seen);
        if (seen !== want)
        begin
            error_count++;
            if (error_count <= MAX_REPORTS)
                $error("%s: expected %02h, actual %02h", name, want, seen);
        end
    endtask

    // ------------------------------------------------------------------
    // Monitor: check each result beat against the oldest prediction, then
    // predict from each byte beat taken in. A result is registered after its
    // byte is taken, so the order within this block is safe.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : monitor
        result_t want;
        result_t beat;
        if (rst_n)
        begin
            if (res.valid && res.ready)
            begin
                if (expected_beats.size() == 0)
                begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $error("result beat with nothing expected: kind %0d data %02h",
                               res.result_kind, res.data_byte);
                end
                else
                begin
                    want = expected_beats[0];
                    expected_beats.delete(0);
                    check_field("result_kind", BYTE_W'(want.result_kind),
                                BYTE_W'(res.result_kind));
                    check_field("data_byte", want.data_byte, res.data_byte);
                    check_field("byte_index", want.byte_index, res.byte_index);
                    check_field("frame_type", want.frame_type, res.frame_type);
                    check_field("frame_length", want.frame_length, res.frame_length);
                    check_field("checksum_ok", BYTE_W'(want.checksum_ok),
                                BYTE_W'(res.checksum_ok));
                end
            end
            if (rx.valid && rx.ready)
            begin
                if (deframe_byte(rx.rx_byte, beat))
                    expected_beats.insert(expected_beats.size(), beat);
            end
        end
    end

    // Result side backpressure: random stalls, no new ones while steady is set.
    always @(posedge clk)
    begin
        if (!rst_n)
            res.ready <= 1'b0;
        else if (stall_left != 0)
        begin
            res.ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else
        begin
            res.ready <= 1'b1;
            if (!steady && $urandom_range(0, 3) == 0)
                stall_left <= pick_gap();
        end
    end

    // Watchdog: end the run once nothing has moved for too long.
    always @(posedge clk)
    begin
        if ((rx.valid && rx.ready) || (res.valid && res.ready) || cfg_wr_en || !rst_n)
            idle_cycles <= 0;
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("tb_serial_frame_deframer_xor: done, errors");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers; all are entered just after a rising edge.
    // ------------------------------------------------------------------

    // Offer one byte, hold it until taken, then idle for a random gap.
    // Valid stays high across back-to-back beats.
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        int gap;
        rx.valid   <= 1'b1;
        rx.rx_byte <= b;
        @(posedge clk);
        while (!rx.ready)
            @(posedge clk);
        gap = steady ? 0 : pick_gap();
        if (gap != 0)
        begin
            rx.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Send a whole frame with the current sync bytes; corrupt flips
    // checksum bits.
    task automatic send_frame(input logic [BYTE_W-1:0] ftype, input byte_q_t payload,
                              input bit corrupt);
        logic [BYTE_W-1:0] flen;
        logic [BYTE_W-1:0] sum;
        flen = BYTE_W'(payload.size());
        sum  = sync1 ^ sync2 ^ ftype ^ flen;
        send_byte(sync1);
        send_byte(sync2);
        send_byte(ftype);
        send_byte(flen);
        foreach (payload[i])
        begin
            sum = sum ^ payload[i];
            send_byte(payload[i]);
        end
        if (corrupt)
            sum = sum ^ BYTE_W'($urandom_range(1, 255));
        send_byte(sum);
        frame_bytes += 5 + payload.size();
    endtask

    // Drop valid, drain every expected beat, then let the block settle.
    task automatic wait_idle();
        rx.valid <= 1'b0;
        @(posedge clk);
        while (expected_beats.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write both sync byte registers on back-to-back edges.
    task automatic set_sync_bytes(input logic [BYTE_W-1:0] first,
                                  input logic [BYTE_W-1:0] second);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_FIRST_HEADER;
        cfg_data  <= first;
        @(posedge clk);
        cfg_index <= CFG_SECOND_HEADER;
        cfg_data  <= second;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        sync1 = first;
        sync2 = second;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset sync bytes: empty frame, extreme type and payload values, a bad
    // checksum, a wrong second sync byte and noise while hunting.
    task automatic test_frame_basics();
        byte_q_t none;
        send_frame(8'h00, none, 1'b0);
        send_frame(8'hFF, '{8'hFF}, 1'b1);
        // Wrong second sync byte: the repeated first sync byte is not taken
        // as a new start, so the trailing second sync byte is ignored too.
        send_byte(sync1);
        send_byte(sync1);
        send_byte(sync2);
        send_byte(8'h00);
        send_frame(8'h5A, '{8'h00, 8'hFF, 8'h80}, 1'b0);
    endtask

    // Sync byte registers at their extremes and with both bytes equal.
    task automatic test_sync_bytes();
        byte_q_t none;
        wait_idle();
        set_sync_bytes(8'h00, 8'hFF);
        send_byte(8'hFF);
        send_frame(8'h01, '{8'h10}, 1'b0);
        wait_idle();
        set_sync_bytes(8'hFF, 8'h00);
        send_frame(8'h80, none, 1'b0);
        send_frame(8'h7F, '{8'hFF, 8'h00}, 1'b1);
        wait_idle();
        // Equal sync bytes: a run of them shifts where the frame is seen.
        set_sync_bytes(8'h3C, 8'h3C);
        send_byte(8'h3C);
        send_frame(8'h3C, '{8'h3C, 8'hC3}, 1'b0);
        send_frame(8'h21, '{8'h42}, 1'b0);
    endtask

    // Random mix over three sync settings; mostly good frames with random
    // content, the rest corrupted, cut short, wrongly synced or noise.
    task automatic test_random_traffic();
        byte_q_t           pl;
        int                target;
        int                len;
        int                n;
        int unsigned       pick;
        logic [BYTE_W-1:0] b;
        for (int phase = 0; phase < 3; phase++)
        begin
            wait_idle();
            if (phase == 0)
                set_sync_bytes(FIRST_HEADER_RESET, SECOND_HEADER_RESET);
            else
                set_sync_bytes(BYTE_W'($urandom_range(0, 255)),
                               BYTE_W'($urandom_range(0, 255)));
            if (phase == 2)
            begin
                // One maximum length frame to reach the top payload index.
                pl.delete();
                repeat (255) pl.insert(pl.size(), BYTE_W'($urandom_range(0, 255)));
                send_frame(BYTE_W'($urandom_range(0, 255)), pl, 1'b0);
            end
            target = frame_bytes + RANDOM_BYTES / 3;
            while (frame_bytes < target)
            begin
                steady = ($urandom_range(0, 7) == 0);
                pick   = $urandom_range(0, 99);
                if (pick < 80)
                begin
                    // Mostly short frames, some medium, rarely near the top.
                    n = $urandom_range(0, 99);
                    if (n < 80)
                        len = $urandom_range(0, 6);
                    else if (n < 97)
                        len = $urandom_range(7, 40);
                    else
                        len = $urandom_range(200, 255);
                    pl.delete();
                    repeat (len) pl.insert(pl.size(), BYTE_W'($urandom_range(0, 255)));
                    send_frame(BYTE_W'($urandom_range(0, 255)), pl, pick >= 70);
                end
                else if (pick < 87)
                begin
                    // Wrong second sync byte, sometimes a repeated first one.
                    send_byte(sync1);
                    if ($urandom_range(0, 1) == 0 && sync1 != sync2)
                        b = sync1;
                    else
                    begin
                        b = BYTE_W'($urandom_range(0, 255));
                        while (b == sync2)
                            b = BYTE_W'($urandom_range(0, 255));
                    end
                    send_byte(b);
                end
                else if (pick < 93)
                begin
                    // Frame cut short: what follows is taken as its payload.
                    len = $urandom_range(2, 20);
                    n   = $urandom_range(0, len - 1);
                    send_byte(sync1);
                    send_byte(sync2);
                    send_byte(BYTE_W'($urandom_range(0, 255)));
                    send_byte(BYTE_W'(len));
                    repeat (n) send_byte(BYTE_W'($urandom_range(0, 255)));
                    frame_bytes += 4 + n;
                end
                else
                begin
                    repeat ($urandom_range(1, 6)) send_byte(BYTE_W'($urandom_range(0, 255)));
                end
            end
            steady = 1'b0;
        end
    endtask

    initial
    begin
        clk        = 1'b0;
        rst_n      = 1'b0;
        cfg_wr_en  = 1'b0;
        cfg_index  = CFG_FIRST_HEADER;
        cfg_data   = '0;
        rx.valid   = 1'b0;
        rx.rx_byte = '0;

        // Hold reset, then release on an edge.
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_frame_basics();
        test_sync_bytes();
        test_random_traffic();

        // Drain everything, then give stray beats time to show up.
        wait_idle();
        repeat (2 * SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("tb_serial_frame_deframer_xor: done, clean");
        else
            $display("tb_serial_frame_deframer_xor: done, errors");
        $finish;
    end

endmodule
`default_nettype wire

// ===== serial_frame_deframer_xor.f =====
rtl/core/sfd_pkg.sv
rtl/core/sfd_if.sv
rtl/core/serial_frame_deframer_xor.sv
tb/tb_serial_frame_deframer_xor.sv
